// ===== rtl/pad_pkg.sv =====
// Shared types and constants of the PWM angle decoder.
package pad_pkg;

  localparam int TICK_W     = 16;
  localparam int DUTY_W     = 17;
  localparam int GAIN_W     = 18;
  localparam int RAW_W      = 18;
  localparam int ANGLE_W    = 32;
  localparam int ALPHA_W    = 16;
  localparam int TPM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;
  localparam int DIV_Q_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_GAIN         = 3'd0,
    REG_HORIZONTAL_OFFSET = 3'd1,
    REG_SIGN_NEGATIVE     = 3'd2,
    REG_FILTER_ALPHA      = 3'd3,
    REG_PERIOD_MIN        = 3'd4,
    REG_PERIOD_MAX        = 3'd5,
    REG_TICKS_PER_MICRO   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        duty_gain;
    logic signed [RAW_W-1:0]  horizontal_offset;
    logic                     sign_negative;
    logic [ALPHA_W-1:0]       filter_alpha;
    logic [TICK_W-1:0]        period_min;
    logic [TICK_W-1:0]        period_max;
    logic [TPM_W-1:0]         ticks_per_micro;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    duty_gain:         18'd92160,
    horizontal_offset: 18'sd0,
    sign_negative:     1'b0,
    filter_alpha:      16'd6554,
    period_min:        16'd500,
    period_max:        16'd5000,
    ticks_per_micro:   8'd1
  };

endpackage

// ===== rtl/pad_if.sv =====
// Handshake channel interfaces for captures, results and configuration writes.
interface pad_cap_if import pad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] period_count;
  logic [TICK_W-1:0] high_count;

  modport source(output valid, period_count, high_count, input ready);
  modport sink(input valid, period_count, high_count, output ready);
endinterface

interface pad_res_if import pad_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      good;
  logic [DUTY_W-1:0]         duty_fraction;
  logic signed [ANGLE_W-1:0] unwrapped_angle;
  logic signed [ANGLE_W-1:0] beam_angle;
  logic [TICK_W-1:0]         period_micros;
  logic [TICK_W-1:0]         high_micros;

  modport source(output valid, good, duty_fraction, unwrapped_angle, beam_angle,
                 period_micros, high_micros, input ready);
  modport sink(input valid, good, duty_fraction, unwrapped_angle, beam_angle,
               period_micros, high_micros, output ready);
endinterface

interface pad_cfg_if import pad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/pad_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module pad_divider import pad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_Q_W-1:0] quotient_o
);

  localparam int CntW = $clog2(DIV_Q_W + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q;
  logic [DIV_D_W-1:0] rem_q, dvs_q;
  logic [DIV_Q_W-1:0] dvd_q, quot_q;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial = {rem_q, dvd_q[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CntW'(DIV_Q_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !start_i && (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DIV_D_W'(dividend_i[DIV_N_W-1:DIV_Q_W]);
      dvd_q  <= dividend_i[DIV_Q_W-1:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      dvd_q  <= {dvd_q[DIV_Q_W-2:0], 1'b0};
      quot_q <= {quot_q[DIV_Q_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ===== rtl/pad_cfg_regs.sv =====
// Configuration register file with its write channel.
module pad_cfg_regs import pad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pad_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o,
  output logic       wr_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    wr    = 1'b0;
    if (cfg_i.valid) begin
      wr = 1'b1;
      unique case (cfg_i.index)
        REG_DUTY_GAIN:         cfg_d.duty_gain = cfg_i.data;
        REG_HORIZONTAL_OFFSET: cfg_d.horizontal_offset = $signed(cfg_i.data);
        REG_SIGN_NEGATIVE:     cfg_d.sign_negative = cfg_i.data[0];
        REG_FILTER_ALPHA:      cfg_d.filter_alpha = cfg_i.data[ALPHA_W-1:0];
        REG_PERIOD_MIN:        cfg_d.period_min = cfg_i.data[TICK_W-1:0];
        REG_PERIOD_MAX:        cfg_d.period_max = cfg_i.data[TICK_W-1:0];
        REG_TICKS_PER_MICRO:   cfg_d.ticks_per_micro = cfg_i.data[TPM_W-1:0];
        default:               wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign wr_o  = wr;

endmodule

// ===== rtl/pwm_angle_decoder_unit.sv =====
// PWM angle decoder top level: sequencer, tracker state and shared arithmetic.
//
// Captures arrive on cap_i as one beat of period and high time in timer ticks.
// Each capture yields exactly one result beat on res_o. cap_i is ready only
// while the sequencer is idle; a capture is worked on alone.
// A rejected capture goes from the check state straight to S_DONE and the result
// register. A good capture runs three divisions (duty cycle, period
// microseconds, high microseconds) one after another on the shared restoring
// divider, and the gain and filter products use one shared multiplier
// while the period division runs.
// The result sits in an output register, so a new capture is accepted while
// an older result still waits; when the receiver stalls and a second result
// is ready, the sequencer holds it until the register frees.
// cfg_i is always ready; a write to a listed register restarts priming.
// Writes are expected only while no capture is in flight.
// Reset loads the register defaults, clears the tracker and empties the
// output register.
module pwm_angle_decoder_unit import pad_pkg::*; #(
  parameter int TICK_BITS        = 16,
  parameter int PRIMING_CAPTURES = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pad_cap_if.sink    cap_i,
  pad_res_if.source  res_o,
  pad_cfg_if.sink    cfg_i
);

  localparam int MaskBits = (TICK_BITS < TICK_W) ? TICK_BITS : TICK_W;
  localparam logic [TICK_W-1:0] TickMask = TICK_W'((33'd1 << MaskBits) - 33'd1);
  localparam logic [1:0] PrimeCnt = 2'(PRIMING_CAPTURES);
  localparam logic signed [19:0] HalfTurn = 20'sd46080;
  localparam logic signed [19:0] FullTurn = 20'sd92160;
  localparam logic signed [35:0] SatMax = 36'sd2147483647;
  localparam logic signed [35:0] SatMin = -36'sd2147483648;
  localparam logic signed [51:0] RoundHalf = 52'sd32768;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DUTY, S_GAIN, S_TRACK, S_ALPHA, S_FILT, S_BEAM,
    S_PMIC, S_HMIC, S_DONE
  } state_e;

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [35:0] v);
    if (v > SatMax) begin
      return ANGLE_W'(SatMax);
    end else if (v < SatMin) begin
      return ANGLE_W'(SatMin);
    end
    return v[ANGLE_W-1:0];
  endfunction

  cfg_t cfg;
  logic cfg_wr;

  pad_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .wr_o   (cfg_wr)
  );

  state_e state_q;
  logic   primed_q;
  logic [1:0] count_q;
  logic   reject_q, prime_only_q;
  logic   res_valid_q;
  logic [RAW_W-1:0] last_raw_q;
  logic signed [ANGLE_W-1:0] cont_q, filt_q, beam_q;

  logic [TICK_W-1:0] per_q, hi_q;
  logic [DUTY_W-1:0] duty_q;
  logic signed [51:0] prod_q;
  logic [TICK_W-1:0] pmic_q, hmic_q;

  logic                      out_good_q;
  logic [DUTY_W-1:0]         out_duty_q;
  logic signed [ANGLE_W-1:0] out_unwrap_q, out_beam_q;
  logic [TICK_W-1:0]         out_pmic_q, out_hmic_q;

  logic cap_acc, bad, load_out;
  logic div_start, div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_Q_W-1:0] div_q;

  logic [TPM_W-1:0] tpm_eff;
  logic [TICK_W:0]  per_rnd, hi_rnd;

  logic [DUTY_W-1:0]        mul_a;
  logic signed [33:0]       mul_b;
  logic signed [51:0]       mul_p;
  logic signed [51:0]       rnd_sum;
  logic [RAW_W-1:0]         raw;
  logic signed [35:0]       step;
  logic signed [19:0]       d0, d1, d2;
  logic signed [32:0]       diff;
  logic signed [33:0]       beam_a, beam_s;

  assign cap_i.ready = (state_q == S_IDLE);
  assign cap_acc     = cap_i.valid && cap_i.ready;

  assign bad = (per_q == '0) || (per_q < cfg.period_min) || (per_q > cfg.period_max)
            || (hi_q > per_q);

  assign tpm_eff = (cfg.ticks_per_micro == '0) ? TPM_W'(1) : cfg.ticks_per_micro;
  assign per_rnd = {1'b0, per_q} + (TICK_W+1)'(tpm_eff >> 1);
  assign hi_rnd  = {1'b0, hi_q} + (TICK_W+1)'(tpm_eff >> 1);

  always_comb begin
    div_start = 1'b0;
    div_n     = DIV_N_W'(hi_rnd);
    div_d     = DIV_D_W'(tpm_eff);
    case (state_q)
      S_CHECK: begin
        div_start = !bad;
        div_n     = {hi_q, 16'd0} + DIV_N_W'(per_q >> 1);
        div_d     = per_q;
      end
      S_DUTY: begin
        div_start = div_done;
        div_n     = DIV_N_W'(per_rnd);
      end
      S_PMIC: begin
        div_start = div_done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pad_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign diff  = {cont_q[ANGLE_W-1], cont_q} - {filt_q[ANGLE_W-1], filt_q};
  assign mul_a = (state_q == S_ALPHA) ? {1'b0, cfg.filter_alpha} : duty_q;
  assign mul_b = (state_q == S_ALPHA) ? {diff[32], diff} : {16'd0, cfg.duty_gain};
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  assign rnd_sum = prod_q + RoundHalf;
  assign raw     = rnd_sum[33:16];
  assign step    = rnd_sum[51:16];

  always_comb begin
    d0 = $signed({2'b0, raw}) - $signed({2'b0, last_raw_q});
    d1 = (d0 > HalfTurn) ? d0 - FullTurn : d0;
    d2 = (d1 < -HalfTurn) ? d1 + FullTurn : d1;
  end

  assign beam_a = {{2{filt_q[ANGLE_W-1]}}, filt_q}
                - {{16{cfg.horizontal_offset[RAW_W-1]}}, cfg.horizontal_offset};
  assign beam_s = cfg.sign_negative ? -beam_a : beam_a;

  assign load_out = (state_q == S_DONE) && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      primed_q     <= 1'b0;
      count_q      <= '0;
      reject_q     <= 1'b0;
      prime_only_q <= 1'b0;
      res_valid_q  <= 1'b0;
      last_raw_q   <= '0;
      cont_q       <= '0;
      filt_q       <= '0;
      beam_q       <= '0;
    end else begin
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cap_acc) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          reject_q     <= bad;
          prime_only_q <= 1'b0;
          state_q      <= bad ? S_DONE : S_DUTY;
        end
        S_DUTY: begin
          if (div_done) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          state_q <= S_TRACK;
        end
        S_TRACK: begin
          last_raw_q <= raw;
          if (!primed_q) begin
            if (count_q < PrimeCnt) begin
              count_q      <= count_q + 1'b1;
              prime_only_q <= 1'b1;
              state_q      <= S_PMIC;
            end else begin
              cont_q   <= $signed({14'd0, raw});
              filt_q   <= $signed({14'd0, raw});
              primed_q <= 1'b1;
              state_q  <= S_BEAM;
            end
          end else begin
            cont_q  <= sat32({{4{cont_q[ANGLE_W-1]}}, cont_q} + 36'(d2));
            state_q <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          state_q <= S_FILT;
        end
        S_FILT: begin
          filt_q  <= sat32({{4{filt_q[ANGLE_W-1]}}, filt_q} + step);
          state_q <= S_BEAM;
        end
        S_BEAM: begin
          beam_q  <= sat32(36'(beam_s));
          state_q <= S_PMIC;
        end
        S_PMIC: begin
          if (div_done) begin
            state_q <= S_HMIC;
          end
        end
        S_HMIC: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cfg_wr) begin
        primed_q <= 1'b0;
        count_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_acc) begin
      per_q <= cap_i.period_count & TickMask;
      hi_q  <= cap_i.high_count & TickMask;
    end
    if (state_q == S_DUTY && div_done) begin
      duty_q <= div_q;
    end
    if (state_q == S_GAIN || state_q == S_ALPHA) begin
      prod_q <= mul_p;
    end
    if (state_q == S_PMIC && div_done) begin
      pmic_q <= div_q[TICK_W-1:0];
    end
    if (state_q == S_HMIC && div_done) begin
      hmic_q <= div_q[TICK_W-1:0];
    end
    if (load_out) begin
      out_good_q   <= !reject_q && !prime_only_q;
      out_duty_q   <= reject_q ? '0 : duty_q;
      out_unwrap_q <= (reject_q || prime_only_q) ? '0 : cont_q;
      out_beam_q   <= (reject_q || prime_only_q) ? '0 : beam_q;
      out_pmic_q   <= (reject_q || prime_only_q) ? '0 : pmic_q;
      out_hmic_q   <= (reject_q || prime_only_q) ? '0 : hmic_q;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.good            = out_good_q;
  assign res_o.duty_fraction   = out_duty_q;
  assign res_o.unwrapped_angle = out_unwrap_q;
  assign res_o.beam_angle      = out_beam_q;
  assign res_o.period_micros   = out_pmic_q;
  assign res_o.high_micros     = out_hmic_q;

  a_prime_from_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(primed_q) |-> $past(state_q) == S_TRACK)
    else $error("tracker primed outside the tracking step");

  a_cfg_restarts_priming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !primed_q && count_q == 2'd0)
    else $error("configuration write did not restart priming");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DUTY || state_q == S_PMIC || state_q == S_HMIC))
    else $error("divider finished while the sequencer was not waiting");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> out_duty_q <= 17'd65536)
    else $error("duty fraction above full scale");

endmodule

// ===== sim/pwm_angle_decoder_unit_tb.sv =====
// Self-checking testbench for the PWM angle decoder with its own tracker predictor.
module pwm_angle_decoder_unit_tb;
  import pad_pkg::*;

  localparam int     PRIME_CAPTURES = 2;
  localparam int     RANDOM_ITEMS   = 650;
  localparam longint HALF_TURN      = 46080;
  localparam longint FULL_TURN      = 92160;

  typedef struct packed {
    logic                      good;
    logic [DUTY_W-1:0]         duty_fraction;
    logic signed [ANGLE_W-1:0] unwrapped_angle;
    logic signed [ANGLE_W-1:0] beam_angle;
    logic [TICK_W-1:0]         period_micros;
    logic [TICK_W-1:0]         high_micros;
  } angle_result_t;

  typedef struct packed {
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] high;
    logic              typed;
    angle_result_t     want;
  } capture_row_t;

  localparam angle_result_t REJECTED = '0;

  // Rows after reset: rejects, two priming captures, the seed, then tracking and wraps.
  localparam capture_row_t CAPTURE_ROWS [0:20] = '{
    '{16'd0,     16'd0,     1'b1, REJECTED},
    '{16'd499,   16'd0,     1'b1, REJECTED},
    '{16'd5001,  16'd10,    1'b1, REJECTED},
    '{16'd1000,  16'd1001,  1'b1, REJECTED},
    '{16'd65535, 16'd65535, 1'b1, REJECTED},
    '{16'd1000,  16'd500,   1'b1, '{1'b0, 17'd32768, 32'sd0, 32'sd0, 16'd0, 16'd0}},
    '{16'd500,   16'd0,     1'b1, REJECTED},
    '{16'd1000,  16'd250,   1'b1,
      '{1'b1, 17'd16384, 32'sd23040, 32'sd23040, 16'd1000, 16'd250}},
    '{16'd5000,  16'd5000,  1'b0, REJECTED},
    '{16'd4000,  16'd0,     1'b0, REJECTED},
    '{16'd500,   16'd500,   1'b0, REJECTED},
    '{16'd5000,  16'd0,     1'b0, REJECTED},
    '{16'd3000,  16'd1500,  1'b0, REJECTED},
    '{16'd4999,  16'd1,     1'b0, REJECTED},
    '{16'd501,   16'd250,   1'b0, REJECTED},
    '{16'd2000,  16'd2001,  1'b1, REJECTED},
    '{16'd1000,  16'd0,     1'b0, REJECTED},
    '{16'd1000,  16'd1000,  1'b0, REJECTED},
    '{16'd777,   16'd333,   1'b0, REJECTED},
    '{16'd4321,  16'd4321,  1'b0, REJECTED},
    '{16'd600,   16'd301,   1'b0, REJECTED}
  };

  logic clk;
  logic rst_n;

  pad_cap_if cap ();
  pad_res_if res ();
  pad_cfg_if cfg ();

  pwm_angle_decoder_unit #(
    .TICK_BITS       (TICK_W),
    .PRIMING_CAPTURES(PRIME_CAPTURES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cap_i (cap),
    .res_o (res),
    .cfg_i (cfg)
  );

  cfg_t                      tracker_cfg;
  logic [RAW_W-1:0]          last_raw;
  logic signed [ANGLE_W-1:0] cont_angle;
  logic signed [ANGLE_W-1:0] filt_angle;
  logic                      primed;
  int                        prime_count;

  angle_result_t expected_angles [$];
  int            fault_count = 0;
  int            burst_left  = 0;
  int            ready_hold  = 0;
  logic          drain_on    = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [ANGLE_W-1:0] sat32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh8000_0000) - 0 && v < -64'sd2147483648) return 32'sh8000_0000;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic [TICK_W-1:0] ticks_to_micros(input logic [TICK_W-1:0] ticks);
    longint unsigned t;
    t = (tracker_cfg.ticks_per_micro == '0) ? 64'd1 : 64'(tracker_cfg.ticks_per_micro);
    return 16'((64'(ticks) + t / 2) / t);
  endfunction

  function automatic angle_result_t predict_angle(input logic [TICK_W-1:0] period,
                                                  input logic [TICK_W-1:0] high);
    angle_result_t   r;
    longint unsigned duty;
    longint unsigned raw;
    longint          delta;
    longint          diff;
    longint          step_v;
    longint          beam_v;
    r = '0;
    if (period == '0 || period < tracker_cfg.period_min || period > tracker_cfg.period_max ||
        high > period) begin
      return r;
    end
    duty = ((64'(high) << 16) + 64'(period) / 2) / 64'(period);
    raw = ((duty * 64'(tracker_cfg.duty_gain) + 64'd32768) >> 16) & 64'h3FFFF;
    r.duty_fraction = duty[DUTY_W-1:0];
    if (!primed) begin
      if (prime_count < PRIME_CAPTURES) begin
        prime_count++;
        last_raw = raw[RAW_W-1:0];
        return r;
      end
      cont_angle = 32'(raw);
      filt_angle = 32'(raw);
      primed = 1'b1;
    end else begin
      delta = longint'(raw) - longint'(64'(last_raw));
      if (delta > HALF_TURN) delta -= FULL_TURN;
      if (delta < -HALF_TURN) delta += FULL_TURN;
      cont_angle = sat32(longint'(cont_angle) + delta);
      diff = longint'(cont_angle) - longint'(filt_angle);
      step_v = (longint'(tracker_cfg.filter_alpha) * diff + 64'sd32768) >>> 16;
      filt_angle = sat32(longint'(filt_angle) + step_v);
    end
    last_raw = raw[RAW_W-1:0];
    beam_v = longint'(filt_angle) - longint'(tracker_cfg.horizontal_offset);
    if (tracker_cfg.sign_negative) beam_v = -beam_v;
    r.good = 1'b1;
    r.unwrapped_angle = cont_angle;
    r.beam_angle = sat32(beam_v);
    r.period_micros = ticks_to_micros(period);
    r.high_micros = ticks_to_micros(high);
    return r;
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 40) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic send_capture(input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] high,
                              input logic typed, input angle_result_t want);
    angle_result_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      cap.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    cap.valid <= 1'b1;
    cap.period_count <= period;
    cap.high_count <= high;
    do @(posedge clk); while (!cap.ready);
    predicted = predict_angle(period, high);
    expected_angles.push_back(typed ? want : predicted);
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    cap.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_DUTY_GAIN:         tracker_cfg.duty_gain = data;
      REG_HORIZONTAL_OFFSET: tracker_cfg.horizontal_offset = data;
      REG_SIGN_NEGATIVE:     tracker_cfg.sign_negative = data[0];
      REG_FILTER_ALPHA:      tracker_cfg.filter_alpha = data[ALPHA_W-1:0];
      REG_PERIOD_MIN:        tracker_cfg.period_min = data[TICK_W-1:0];
      REG_PERIOD_MAX:        tracker_cfg.period_max = data[TICK_W-1:0];
      REG_TICKS_PER_MICRO:   tracker_cfg.ticks_per_micro = data[TPM_W-1:0];
      default: ;
    endcase
    primed = 1'b0;
    prime_count = 0;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic configure_phase(input int k);
    logic [GAIN_W-1:0]  gain;
    logic [RAW_W-1:0]   offs;
    logic               sgn;
    logic [ALPHA_W-1:0] alpha;
    logic [TICK_W-1:0]  pmin;
    logic [TICK_W-1:0]  pmax;
    logic [TPM_W-1:0]   tpm;
    int                 sel;
    case (k)
      0: begin
        gain = 18'd262143; offs = 18'd92160; sgn = 1'b1; alpha = 16'hFFFF;
        pmin = 16'd0; pmax = 16'hFFFF; tpm = 8'd0;
      end
      1: begin
        gain = 18'd256; offs = 18'(-92160); sgn = 1'b0; alpha = 16'd0;
        pmin = 16'd1; pmax = 16'hFFFF; tpm = 8'd255;
      end
      default: begin
        sel = $urandom_range(0, 3);
        gain = (sel == 0) ? 18'd92160 : (sel == 1) ? 18'd256 :
               (sel == 2) ? 18'd262143 : 18'($urandom);
        offs = ($urandom_range(0, 4) == 0) ? 18'($urandom) :
               18'(int'($urandom_range(0, 184320)) - 92160);
        sgn = 1'($urandom);
        sel = $urandom_range(0, 3);
        alpha = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : (sel == 2) ? 16'd6554 :
                16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          pmin = 16'($urandom_range(2000, 65535));
          pmax = 16'($urandom_range(0, int'(pmin) - 1));
        end else begin
          pmin = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 1500));
          pmax = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1500, 65535));
        end
        sel = $urandom_range(0, 3);
        tpm = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd1 : (sel == 2) ? 8'd255 : 8'($urandom);
      end
    endcase
    write_reg(REG_DUTY_GAIN, gain);
    write_reg(REG_HORIZONTAL_OFFSET, offs);
    write_reg(REG_SIGN_NEGATIVE, {17'($urandom), sgn});
    write_reg(REG_FILTER_ALPHA, {2'($urandom), alpha});
    write_reg(REG_PERIOD_MIN, {2'($urandom), pmin});
    write_reg(REG_PERIOD_MAX, {2'($urandom), pmax});
    write_reg(REG_TICKS_PER_MICRO, {10'($urandom), tpm});
  endtask

  // The receiver alternates drain and stall runs, with random dropouts while draining.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      drain_on = !drain_on;
      ready_hold = drain_on ? $urandom_range(1, 30) : $urandom_range(1, 12);
    end
    ready_hold--;
    res.ready <= drain_on && ($urandom_range(0, 6) != 0 || ready_hold > 20);
  end

  always @(posedge clk) begin
    angle_result_t want;
    if (rst_n && res.valid && res.ready) begin
      if (expected_angles.size() == 0) begin
        report_fault("result beat with no capture outstanding");
      end else begin
        want = expected_angles.pop_front();
        if (res.good !== want.good)
          report_fault($sformatf("good %0b, expected %0b", res.good, want.good));
        if (res.duty_fraction !== want.duty_fraction)
          report_fault($sformatf("duty_fraction %0d, expected %0d",
                                 res.duty_fraction, want.duty_fraction));
        if (res.unwrapped_angle !== want.unwrapped_angle)
          report_fault($sformatf("unwrapped_angle %0d, expected %0d",
                                 res.unwrapped_angle, want.unwrapped_angle));
        if (res.beam_angle !== want.beam_angle)
          report_fault($sformatf("beam_angle %0d, expected %0d",
                                 res.beam_angle, want.beam_angle));
        if (res.period_micros !== want.period_micros)
          report_fault($sformatf("period_micros %0d, expected %0d",
                                 res.period_micros, want.period_micros));
        if (res.high_micros !== want.high_micros)
          report_fault($sformatf("high_micros %0d, expected %0d",
                                 res.high_micros, want.high_micros));
      end
    end
  end

  initial begin
    int                random_sent;
    int                phase;
    int                n;
    int                pick;
    int                lo;
    int                hi;
    int                rot_rate;
    int                rot_duty;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] high;
    rst_n = 1'b0;
    cap.valid = 1'b0;
    cap.period_count = '0;
    cap.high_count = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_DUTY_GAIN;
    cfg.data = '0;
    tracker_cfg = CFG_RESET;
    last_raw = '0;
    cont_angle = '0;
    filt_angle = '0;
    primed = 1'b0;
    prime_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (CAPTURE_ROWS[i]) begin
      send_capture(CAPTURE_ROWS[i].period, CAPTURE_ROWS[i].high, CAPTURE_ROWS[i].typed,
                   CAPTURE_ROWS[i].want);
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle_pipeline();
      configure_phase(phase);
      n = (tracker_cfg.period_min > tracker_cfg.period_max) ? 8 : $urandom_range(20, 80);
      lo = (tracker_cfg.period_min == '0) ? 1 : int'(tracker_cfg.period_min);
      hi = int'(tracker_cfg.period_max);
      rot_rate = int'($urandom_range(0, 16000)) - 8000;
      rot_duty = $urandom_range(0, 65535);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 10 || lo > hi) begin
          period = 16'($urandom);
          high = 16'($urandom);
        end else if (pick < 14) begin
          period = '0;
          high = 16'($urandom);
        end else if (pick < 19) begin
          period = 16'($urandom_range(lo, hi));
          high = (period == 16'hFFFF) ? period :
                 16'($urandom_range(int'(period) + 1, 65535));
        end else begin
          period = 16'($urandom_range(lo, hi));
          if ($urandom_range(0, 9) == 0) rot_duty = $urandom_range(0, 65535);
          rot_duty = (rot_duty + rot_rate) & 16'hFFFF;
          if (pick < 24) high = '0;
          else if (pick < 29) high = period;
          else high = 16'((longint'(period) * longint'(rot_duty)) >>> 16);
        end
        send_capture(period, high, 1'b0, REJECTED);
        random_sent++;
      end
      phase++;
    end

    settle_pipeline();
    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
